/* rtl/pbi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette builder and indexer package
// Beat types, queue entry type and shared helpers for the palette indexer.
// ----------------------------------------------------------------------------
package pbi_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;

   localparam logic [31:0] GRAY_MASK = 32'h0000_ffff;
   localparam logic [31:0] FULL_MASK = 32'hffff_ffff;
   localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;

   typedef struct packed {
      logic        start_of_image;
      logic [31:0] pixel_value;
   } pbi_req_type;

   typedef struct packed {
      logic [3:0]  palette_index;
      logic        is_new_color;
      logic [31:0] palette_word;
      logic [4:0]  color_count;
      logic [1:0]  depth_code;
      logic        overflow;
   } pbi_rsp_type;

   typedef struct packed {
      logic        start_of_image;
      logic        gray;
      logic [31:0] pix;
   } pbi_item_type;

   typedef struct packed {
      logic         valid;
      pbi_item_type item;
   } pbi_queue_type;

   function automatic logic [31:0] render_word(input logic [31:0] entry, input logic gray);
      logic [7:0] g;
      g = entry[7:0];
      render_word = gray ? {g, g, g, ALPHA_OPAQUE} : entry;
   endfunction

endpackage

/* rtl/pbi_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/pbi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette indexer front end
// Accepts pixel beats, applies the pixel format mask and queues them.
// ----------------------------------------------------------------------------
module pbi_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pbi_pkg::pbi_req_type req_payload,
   input  logic                 gray_mode,
   output pbi_pkg::pbi_queue_type q,
   input  logic                 q_pop
);

   import pbi_pkg::*;

   pbi_item_type      slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   fill_ff, fill_in;
   logic              push;
   logic              pop;
   pbi_item_type      item;

   assign busy = (fill_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign push = start && !busy;
   assign pop  = q_pop && (fill_ff != '0);

   always_comb begin
      item.start_of_image = req_payload.start_of_image;
      item.gray           = gray_mode;
      item.pix            = req_payload.pixel_value & (gray_mode ? GRAY_MASK : FULL_MASK);
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

   assign q.valid = (fill_ff != '0);
   assign q.item  = slot_ff[rd_ptr_ff];

endmodule

/* rtl/pbi_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette indexer back end
// Scans the palette RAM for a queued pixel, appends new colors, forms results.
// ----------------------------------------------------------------------------
module pbi_back #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pbi_pkg::pbi_queue_type q,
   output logic                  q_pop,
   output logic                  rsp_valid,
   output pbi_pkg::pbi_rsp_type  rsp_payload
);

   import pbi_pkg::*;

   localparam int IW = $clog2(PALETTE_DEPTH);
   localparam int CW = $clog2(PALETTE_DEPTH + 1);
   localparam int IX = (IW > 4) ? IW : 4;
   localparam int CX = (CW > 5) ? CW : 5;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } state_type;

   state_type    state_ff, state_in;
   pbi_item_type cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] cmp_idx_ff, cmp_idx_in;
   logic          cmp_valid_ff, cmp_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pbi_rsp_type   rsp_ff, rsp_in;

   logic [31:0]   rdata;
   logic [31:0]   mask;
   logic          issue;
   logic          hit;
   logic          last;
   logic          finish;
   logic          full;
   logic          ram_we;
   logic [IW-1:0] idx;
   logic [IX-1:0] idx_x;
   logic [CX-1:0] cnt_x;

   pbi_ram #(
      .WIDTH (32),
      .DEPTH (PALETTE_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (count_ff[IW-1:0]),
      .wdata (cur_ff.pix),
      .raddr (scan_ff[IW-1:0]),
      .rdata (rdata)
   );

   assign mask   = cur_ff.gray ? GRAY_MASK : FULL_MASK;
   assign issue  = (scan_ff < count_ff);
   assign hit    = cmp_valid_ff && ((rdata & mask) == cur_ff.pix);
   assign last   = (CW'(cmp_idx_ff) + 1'b1 == count_ff);
   assign finish = hit || (cmp_valid_ff && last) || (count_ff == '0);
   assign full   = (count_ff == CW'(PALETTE_DEPTH));

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;
      ram_we       = 1'b0;
      idx          = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (q.valid) begin
               q_pop    = 1'b1;
               cur_in   = q.item;
               count_in = q.item.start_of_image ? '0 : count_ff;
               scan_in  = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               cmp_valid_in = 1'b1;
               cmp_idx_in   = scan_ff[IW-1:0];
               scan_in      = scan_ff + 1'b1;
            end
            if (finish) begin
               state_in            = S_IDLE;
               cmp_valid_in        = 1'b0;
               rsp_valid_in        = 1'b1;
               rsp_in.is_new_color = 1'b0;
               rsp_in.overflow     = 1'b0;
               rsp_in.palette_word = '0;
               if (hit) begin
                  idx                 = cmp_idx_ff;
                  rsp_in.palette_word = render_word(rdata, cur_ff.gray);
               end else if (!full) begin
                  ram_we              = 1'b1;
                  idx                 = count_ff[IW-1:0];
                  count_in            = count_ff + 1'b1;
                  rsp_in.is_new_color = 1'b1;
                  rsp_in.palette_word = render_word(cur_ff.pix, cur_ff.gray);
               end else begin
                  rsp_in.overflow = 1'b1;
               end
               idx_x                = IX'(idx);
               cnt_x                = CX'(count_in);
               rsp_in.palette_index = idx_x[3:0];
               rsp_in.color_count   = cnt_x[4:0];
               if (cnt_x <= CX'(2)) begin
                  rsp_in.depth_code = 2'd0;
               end else if (cnt_x <= CX'(4)) begin
                  rsp_in.depth_code = 2'd1;
               end else if (cnt_x < CX'(16)) begin
                  rsp_in.depth_code = 2'd2;
               end else begin
                  rsp_in.depth_code = 2'd3;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      idx_x = IX'(idx);
      cnt_x = CX'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      scan_ff    <= scan_in;
      cmp_idx_ff <= cmp_idx_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(PALETTE_DEPTH))
      else $error("palette entry count above depth");

   a_write_when_room: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN) && !full && !hit)
      else $error("palette write without room or on a hit");

   a_new_grows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && rsp_in.is_new_color) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("new color did not grow the palette");

   a_overflow_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.overflow) |->
         !rsp_ff.is_new_color && (rsp_ff.palette_index == '0) && (rsp_ff.palette_word == '0))
      else $error("overflow result carries an entry");

endmodule

/* rtl/palette_builder_indexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette builder and indexer
// Maps pixels to palette indices while building a palette of distinct colors.
// ----------------------------------------------------------------------------
//  Channel   Handshake          Payload
//  request   start / busy       req_payload (start_of_image, pixel_value)
//  response  rsp_valid strobe   rsp_payload (index, new, word, count, depth, overflow)
//  control   csr_we             csr_wdata (gray_alpha_mode)
//
//  A beat taken from the queue yields its result once it matches entry k,
//  or once all n entries have been scanned when it is new or overflows;
//  the scan reads one palette RAM entry per cycle through its single read
//  port. Two beats can wait in the queue.
//  Reset empties the palette count and the mode register. Results are
//  strobed for one cycle and cannot be stalled.
// ----------------------------------------------------------------------------
module palette_builder_indexer #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  pbi_pkg::pbi_req_type req_payload,
   output logic                 rsp_valid,
   output pbi_pkg::pbi_rsp_type rsp_payload,
   input  logic                 csr_we,
   input  logic                 csr_wdata
);

   import pbi_pkg::*;

   logic          gray_mode_ff, gray_mode_in;
   pbi_queue_type q;
   logic          q_pop;

   assign gray_mode_in = csr_we ? csr_wdata : gray_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gray_mode_ff <= 1'b0;
      end else begin
         gray_mode_ff <= gray_mode_in;
      end
   end

   pbi_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .gray_mode   (gray_mode_ff),
      .q           (q),
      .q_pop       (q_pop)
   );

   pbi_back #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q           (q),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

/* verif/palette_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette indexer checker
// Watches the pixel, result and control channels of the palette indexer,
// keeps its own palette and mode, predicts every result beat and compares it
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module palette_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  pbi_pkg::pbi_req_type req_payload,
   input  logic                 rsp_valid,
   input  pbi_pkg::pbi_rsp_type rsp_payload,
   input  logic                 csr_we,
   input  logic                 csr_wdata,
   output int unsigned          fail_count,
   output int unsigned          waiting
);

   localparam int PALETTE_DEPTH = 16;
   localparam int REPORT_LIMIT  = 20;

   logic [31:0]          colors [PALETTE_DEPTH];
   logic [4:0]           used;
   logic                 gray;
   pbi_pkg::pbi_rsp_type predicted_q [$];
   int unsigned          beats_seen;

   function automatic logic [1:0] depth_for(input logic [4:0] n);
      if (n <= 5'd2) begin
         return 2'd0;
      end else if (n <= 5'd4) begin
         return 2'd1;
      end else if (n < 5'd16) begin
         return 2'd2;
      end
      return 2'd3;
   endfunction

   function automatic logic [31:0] shown_word(input logic [31:0] entry);
      if (!gray) begin
         return entry;
      end
      return {entry[7:0], entry[7:0], entry[7:0], 8'hff};
   endfunction

   function automatic pbi_pkg::pbi_rsp_type index_pixel(input pbi_pkg::pbi_req_type beat);
      logic [31:0]          mask;
      logic [31:0]          pix;
      logic                 hit;
      pbi_pkg::pbi_rsp_type r;
      mask = gray ? 32'h0000_ffff : 32'hffff_ffff;
      pix  = beat.pixel_value & mask;
      hit  = 1'b0;
      r    = '0;
      if (beat.start_of_image) begin
         used = '0;
      end
      for (int i = 0; i < PALETTE_DEPTH; i++) begin
         if (!hit && i < used && (colors[i] & mask) == pix) begin
            hit             = 1'b1;
            r.palette_index = 4'(i);
            r.palette_word  = shown_word(colors[i]);
         end
      end
      if (!hit) begin
         if (used < PALETTE_DEPTH) begin
            colors[used[3:0]] = pix;
            r.palette_index   = used[3:0];
            r.is_new_color    = 1'b1;
            r.palette_word    = shown_word(pix);
            used              = used + 5'd1;
         end else begin
            r.overflow = 1'b1;
         end
      end
      r.color_count = used;
      r.depth_code  = depth_for(used);
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0d ns: result beat %0d: %s", $time, beats_seen, msg);
      end
      fail_count++;
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
      end
   endtask

   always @(posedge clock) begin
      pbi_pkg::pbi_rsp_type want;
      if (reset) begin
         predicted_q.delete();
         used = '0;
         gray = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (predicted_q.size() == 0) begin
               report_mismatch("result beat with no pixel pending");
            end else begin
               want = predicted_q.pop_front();
               check_field("palette_index", rsp_payload.palette_index, want.palette_index);
               check_field("is_new_color", rsp_payload.is_new_color, want.is_new_color);
               check_field("palette_word", rsp_payload.palette_word, want.palette_word);
               check_field("color_count", rsp_payload.color_count, want.color_count);
               check_field("depth_code", rsp_payload.depth_code, want.depth_code);
               check_field("overflow", rsp_payload.overflow, want.overflow);
            end
            beats_seen++;
         end
         if (start && !busy) begin
            predicted_q.push_back(index_pixel(req_payload));
         end
         if (csr_we) begin
            gray = csr_wdata;
         end
      end
      waiting <= predicted_q.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Palette indexer testbench
// Drives directed pixels through the palette extremes, overflow and a mode
// change mid-image, then random images built from small color sets in both
// pixel modes, with and without sender gaps. The checker judges every beat.
// ----------------------------------------------------------------------------
module testbench;

   localparam int MAX_COLORS = 24;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic                 csr_we      = 1'b0;
   logic                 csr_wdata   = 1'b0;
   pbi_pkg::pbi_req_type req_payload = '0;
   logic                 busy;
   logic                 rsp_valid;
   pbi_pkg::pbi_rsp_type rsp_payload;
   int unsigned          fail_count;
   int unsigned          waiting;

   logic                 gray_now = 1'b0;
   logic [31:0]          image_colors [MAX_COLORS];
   int unsigned          image_size = 1;
   int unsigned          image_left = 0;
   int unsigned          idle_pct [4] = '{0, 57, 0, 28};

   palette_builder_indexer uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata)
   );

   palette_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .waiting     (waiting)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_pixel(input logic sof, input logic [31:0] pix,
                             input int unsigned gap_pct);
      int unsigned idle;
      idle = 0;
      while (idle < 40 && $urandom_range(0, 99) < gap_pct) begin
         idle++;
      end
      if (idle != 0) begin
         start       <= 1'b0;
         req_payload <= {1'($urandom), 32'($urandom)};
         repeat (idle) @(posedge clock);
      end
      start       <= 1'b1;
      req_payload <= '{start_of_image: sof, pixel_value: pix};
      do @(posedge clock); while (busy);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (waiting != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_gray_mode(input logic v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we   <= 1'b0;
      gray_now = v;
   endtask

   task automatic new_image();
      logic [31:0] base;
      logic [31:0] r;
      base       = $urandom;
      image_size = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
                                              : $urandom_range(17, MAX_COLORS);
      image_left = $urandom_range(4, 60);
      for (int i = 0; i < MAX_COLORS; i++) begin
         r = $urandom;
         image_colors[i] = ($urandom_range(0, 4) == 0) ? {r[31:16], base[15:0]} : r;
      end
   endtask

   task automatic run_images(input int unsigned n, input int unsigned gap_pct);
      logic [31:0] pix;
      logic [31:0] r;
      logic        sof;
      int unsigned pick;
      for (int unsigned k = 0; k < n; k++) begin
         sof = 1'b0;
         if (image_left == 0) begin
            new_image();
            sof = ($urandom_range(0, 7) != 0);
         end
         pick = $urandom_range(0, 99);
         r    = $urandom;
         if (pick < 84) begin
            pix = image_colors[$urandom_range(0, image_size - 1)];
            if (gray_now && r[0]) begin
               pix[31:16] = r[31:16];
            end
         end else if (pick < 90) begin
            pix = {r[31:16], image_colors[0][15:0]};
         end else if (pick < 97) begin
            pix = r;
         end else begin
            pix = r[0] ? 32'hffff_ffff : 32'h0000_0000;
         end
         if ($urandom_range(0, 49) == 0) begin
            sof = 1'b1;
         end
         send_pixel(sof, pix, gap_pct);
         image_left--;
         if ($urandom_range(0, 149) == 0) begin
            drain();
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_pixel(1'b1, 32'h0000_0000, 0);
      send_pixel(1'b0, 32'hffff_ffff, 0);
      send_pixel(1'b0, 32'h0000_0000, 0);
      for (int j = 2; j < 16; j++) begin
         send_pixel(1'b0, 32'h0101_0101 * j, 0);
      end
      send_pixel(1'b0, 32'h8000_0001, 0);
      send_pixel(1'b0, 32'h0f0f_0f0f, 0);

      // The RGBA palette stays while the compare narrows to the low half.
      set_gray_mode(1'b1);
      send_pixel(1'b0, 32'habcd_0000, 0);
      send_pixel(1'b0, 32'h1234_ffff, 0);
      send_pixel(1'b1, 32'hffff_80ff, 0);
      send_pixel(1'b0, 32'h0000_80ff, 0);
      send_pixel(1'b0, 32'h0000_0001, 0);

      for (int p = 0; p < 4; p++) begin
         set_gray_mode((p % 2) == 1);
         run_images(200, idle_pct[p]);
         set_gray_mode((p % 2) == 0);
         run_images(190, idle_pct[p]);
      end

      drain();
      repeat (30) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

/* sim.f */
rtl/pbi_pkg.sv
rtl/pbi_ram.sv
rtl/pbi_front.sv
rtl/pbi_back.sv
rtl/palette_builder_indexer.sv
verif/palette_checker.sv
verif/testbench.sv
